FILE: rtl/averaged_thermostat_hysteresis_core_defines.svh
// assertion macros shared by the thermostat core modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef AVERAGED_THERMOSTAT_HYSTERESIS_CORE_DEFINES_SVH
`define AVERAGED_THERMOSTAT_HYSTERESIS_CORE_DEFINES_SVH

// consequent must hold in the same cycle
`define ATH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the following cycle
`define ATH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ath_pkg.sv
// shared types and constants for the averaged thermostat core
// no dependencies
package ath_pkg;

  localparam int RING_DEPTH    = 32;
  localparam int TEMP_BITS     = 15;
  localparam int BAND_BITS     = 12;
  localparam int WIN_BITS      = 6;
  localparam int TIME_BITS     = 32;
  localparam int SLOT_BITS     = $clog2(RING_DEPTH);
  // running sum holds window * sample plus a sign bit
  localparam int SUM_BITS      = TEMP_BITS + SLOT_BITS + 1;
  localparam int MAG_BITS      = SUM_BITS - 1;
  localparam int STEP_BITS     = $clog2(MAG_BITS);
  localparam int CMP_BITS      = ((TEMP_BITS > BAND_BITS) ? TEMP_BITS : BAND_BITS) + 2;
  localparam int CFG_BITS      = (TEMP_BITS > BAND_BITS) ? TEMP_BITS : BAND_BITS;
  localparam int CFG_ADDR_BITS = 3;

  localparam int IN_FIELD_BITS  = TEMP_BITS + 1 + TIME_BITS;
  localparam int IN_BITS        = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = TEMP_BITS + 3 + TIME_BITS;
  localparam int OUT_BITS       = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(MAG_BITS - 1);

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_TARGET      = 3'd0,
    REG_BASELINE    = 3'd1,
    REG_LOWER_BAND  = 3'd2,
    REG_UPPER_BAND  = 3'd3,
    REG_WINDOW      = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic capture;
    logic update;
    logic load;
    logic step;
    logic finish;
  } ath_cmd_t;

endpackage

FILE: rtl/ath_dp.sv
// datapath: config registers, sample ring, running sum, serial divider, relay logic
// depends on ath_pkg
module ath_dp import ath_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ath_cmd_t                 cmd_i,
  input  logic [IN_BITS-1:0]       in_tdata_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [CFG_BITS-1:0]      cfg_data_i,
  output logic [OUT_BITS-1:0]      out_tdata_o
);

  // configuration
  logic signed [TEMP_BITS-1:0] target_q, baseline_q;
  logic [BAND_BITS-1:0]        lower_q, upper_q;
  logic [WIN_BITS-1:0]         window_q;

  // state
  logic signed [TEMP_BITS-1:0] ring_q [RING_DEPTH];
  logic [SLOT_BITS-1:0]        slot_q, slot_d;
  logic signed [SUM_BITS-1:0]  sum_q, sum_d;
  logic                        primed_q;
  logic                        relay_q;
  logic [TIME_BITS-1:0]        start_q;

  // captured word
  logic signed [TEMP_BITS-1:0] in_temp_q;
  logic                        in_occ_q;
  logic [TIME_BITS-1:0]        in_now_q;

  // divider
  logic [MAG_BITS-1:0]         div_q, div_d;
  logic [WIN_BITS-1:0]         rem_q, rem_d;
  logic                        neg_q;

  // result word
  logic signed [TEMP_BITS-1:0] avg_q;
  logic                        heat_q, tog_q, rv_q;
  logic [TIME_BITS-1:0]        run_q;

  logic [WIN_BITS-1:0]         win_n;
  logic [SLOT_BITS-1:0]        cur_slot;
  logic [WIN_BITS-1:0]         nxt_slot;
  logic signed [SUM_BITS-1:0]  sample_ext, old_ext, n_ext, neg_sum;
  logic [WIN_BITS:0]           trial;
  logic                        fits;
  logic [TEMP_BITS-1:0]        q_low;
  logic signed [TEMP_BITS-1:0] avg_w;
  logic signed [CMP_BITS-1:0]  avg_c, tgt_c, base_c, low_c, up_c;
  logic                        want_on, want_off, tog_w;
  logic                        cfg_known;

  // effective window, clamped to 1..RING_DEPTH
  always_comb begin
    if (window_q == '0) begin
      win_n = WIN_BITS'(1);
    end else if (window_q > WIN_BITS'(RING_DEPTH)) begin
      win_n = WIN_BITS'(RING_DEPTH);
    end else begin
      win_n = window_q;
    end
  end

  // a write to a known register restarts the window
  always_comb begin
    case (cfg_addr_i)
      REG_TARGET, REG_BASELINE, REG_LOWER_BAND, REG_UPPER_BAND, REG_WINDOW: begin
        cfg_known = 1'b1;
      end
      default: begin
        cfg_known = 1'b0;
      end
    endcase
  end

  assign cur_slot   = (WIN_BITS'(slot_q) >= win_n) ? '0 : slot_q;
  assign nxt_slot   = WIN_BITS'(cur_slot) + WIN_BITS'(1);
  assign sample_ext = SUM_BITS'(in_temp_q);
  assign old_ext    = SUM_BITS'(ring_q[cur_slot]);
  assign n_ext      = $signed(SUM_BITS'(win_n));

  always_comb begin
    sum_d  = sum_q;
    slot_d = slot_q;
    if (!primed_q) begin
      sum_d  = sample_ext * n_ext;
      slot_d = (win_n > WIN_BITS'(1)) ? SLOT_BITS'(1) : '0;
    end else begin
      sum_d  = sum_q + sample_ext - old_ext;
      slot_d = (nxt_slot >= win_n) ? '0 : SLOT_BITS'(nxt_slot);
    end
  end

  // restoring divide, one quotient bit per cycle
  assign neg_sum = -sum_q;
  assign trial   = {rem_q, div_q[MAG_BITS-1]};
  assign fits    = trial >= {1'b0, win_n};

  always_comb begin
    div_d = div_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      div_d = sum_q[SUM_BITS-1] ? neg_sum[MAG_BITS-1:0] : sum_q[MAG_BITS-1:0];
      rem_d = '0;
    end else if (cmd_i.step) begin
      div_d = {div_q[MAG_BITS-2:0], fits};
      rem_d = fits ? WIN_BITS'(trial - {1'b0, win_n}) : WIN_BITS'(trial);
    end
  end

  // quotient magnitude, sign restored (truncation toward zero)
  assign q_low = div_q[TEMP_BITS-1:0];
  assign avg_w = neg_q ? $signed(TEMP_BITS'(~q_low + TEMP_BITS'(1))) : $signed(q_low);

  assign avg_c  = CMP_BITS'(avg_w);
  assign tgt_c  = CMP_BITS'(target_q);
  assign base_c = CMP_BITS'(baseline_q);
  assign low_c  = $signed(CMP_BITS'(lower_q));
  assign up_c   = $signed(CMP_BITS'(upper_q));

  always_comb begin
    want_on  = 1'b0;
    want_off = 1'b0;
    if (in_occ_q && (avg_c <= tgt_c - low_c)) begin
      want_on = 1'b1;
    end else if (in_occ_q && (avg_c >= tgt_c + up_c)) begin
      want_off = 1'b1;
    end else if (avg_c <= base_c - low_c) begin
      want_on = 1'b1;
    end else if (!in_occ_q && (avg_c >= base_c + up_c)) begin
      want_off = 1'b1;
    end
  end

  assign tog_w = (want_on && !relay_q) || (want_off && relay_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TEMP_BITS'(1088);
      baseline_q <= TEMP_BITS'(960);
      lower_q    <= BAND_BITS'(16);
      upper_q    <= BAND_BITS'(16);
      window_q   <= WIN_BITS'(20);
      slot_q     <= '0;
      sum_q      <= '0;
      primed_q   <= 1'b0;
      relay_q    <= 1'b0;
      start_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_TARGET: begin
            target_q <= $signed(cfg_data_i[TEMP_BITS-1:0]);
          end
          REG_BASELINE: begin
            baseline_q <= $signed(cfg_data_i[TEMP_BITS-1:0]);
          end
          REG_LOWER_BAND: begin
            lower_q <= cfg_data_i[BAND_BITS-1:0];
          end
          REG_UPPER_BAND: begin
            upper_q <= cfg_data_i[BAND_BITS-1:0];
          end
          REG_WINDOW: begin
            window_q <= cfg_data_i[WIN_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
      if (cfg_we_i && cfg_known) begin
        primed_q <= 1'b0;
      end else if (cmd_i.update) begin
        primed_q <= 1'b1;
      end
      if (cmd_i.update) begin
        sum_q  <= sum_d;
        slot_q <= slot_d;
      end
      if (cmd_i.finish && tog_w) begin
        relay_q <= want_on;
        if (want_on) begin
          start_q <= in_now_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_temp_q <= $signed(in_tdata_i[TEMP_BITS-1:0]);
      in_occ_q  <= in_tdata_i[TEMP_BITS];
      in_now_q  <= in_tdata_i[TEMP_BITS+1 +: TIME_BITS];
    end
    if (cmd_i.update) begin
      if (!primed_q) begin
        for (int i = 0; i < RING_DEPTH; i++) begin
          ring_q[i] <= in_temp_q;
        end
      end else begin
        ring_q[cur_slot] <= in_temp_q;
      end
    end
    if (cmd_i.load) begin
      neg_q <= sum_q[SUM_BITS-1];
    end
    div_q <= div_d;
    rem_q <= rem_d;
    if (cmd_i.finish) begin
      avg_q  <= avg_w;
      heat_q <= tog_w ? want_on : relay_q;
      tog_q  <= tog_w;
      rv_q   <= tog_w && want_off;
      run_q  <= (tog_w && want_off) ? (in_now_q - start_q) : '0;
    end
  end

  assign out_tdata_o = {{(OUT_BITS - OUT_FIELD_BITS){1'b0}},
                        run_q, rv_q, tog_q, heat_q, avg_q};

endmodule

FILE: rtl/ath_ctrl.sv
// controller: sequences capture, ring update, divide and decision; owns the handshakes
// depends on ath_pkg and the core assertion macro header
`include "averaged_thermostat_hysteresis_core_defines.svh"

module ath_ctrl import ath_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ath_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_LOAD,
    ST_DIV,
    ST_DECIDE
  } state_e;

  state_e               state_q;
  logic [STEP_BITS-1:0] step_q;
  logic                 out_valid_q;
  logic                 accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = accept;
    cmd_o.update  = (state_q == ST_UPDATE);
    cmd_o.load    = (state_q == ST_LOAD);
    cmd_o.step    = (state_q == ST_DIV);
    // result register must be free (or emptying) before it is overwritten
    cmd_o.finish  = (state_q == ST_DECIDE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + STEP_BITS'(1);
          if (step_q == STEP_LAST) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (cmd_o.finish) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `ATH_ASSERT_NEXT(a_accept_update, accept, state_q == ST_UPDATE, "accepted word skipped update")
  `ATH_ASSERT_NEXT(a_div_done, (state_q == ST_DIV) && (step_q == STEP_LAST), state_q == ST_DECIDE, "divider overran")
  `ATH_ASSERT_NEXT(a_finish_valid, cmd_o.finish, out_valid_q, "finished result not presented")

endmodule

FILE: rtl/averaged_thermostat_hysteresis_core.sv
// top level of the averaged thermostat with hysteresis
// depends on ath_pkg, ath_ctrl and ath_dp
//
// Each input word is one temperature sample; it produces exactly one result word.
// An accepted item passes through the states that update the sample ring and
// running sum, load the divider, run the restoring divider (one quotient bit per
// cycle over the 20-bit sum magnitude) and decide. The divider sets the
// throughput, as a new word is taken only once the previous item has left the
// decision state. The result sits in an output register, so the next word is
// accepted while a result waits; a word only stalls at its decision cycle if the
// previous result is still not taken. The first sample after reset or after a
// write to a known register fills the whole averaging window. Configuration
// writes are always ready and should be issued only while the core is idle.
module averaged_thermostat_hysteresis_core import ath_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // sample_temp[14:0], occupied[15], now_sec[47:16]
  input  logic [IN_BITS-1:0]       s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // average_temp[14:0], heat_on[15], toggled[16], runtime_valid[17],
  // run_seconds[49:18], zero fill above
  output logic [OUT_BITS-1:0]      m_axis_tdata_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [CFG_BITS-1:0]      cfg_data_i
);

  ath_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  ath_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  ath_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_tdata_i  (s_axis_tdata_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .out_tdata_o (m_axis_tdata_o)
  );

endmodule

FILE: sim/tb_averaged_thermostat_hysteresis_core.sv
// testbench for averaged_thermostat_hysteresis_core: windowed average, hysteresis, runtime
// needs ath_pkg and the core rtl; own predictor, queue-fed driver, clocked monitor
module tb_averaged_thermostat_hysteresis_core import ath_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE_LAST  = 3'd7;
  localparam int TEMP_MIN = -(1 << (TEMP_BITS - 1));
  localparam int TEMP_MAX = (1 << (TEMP_BITS - 1)) - 1;
  localparam int PHASES = 12;
  localparam int PHASE_SAMPLES = 96;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_e;

  // packed in bus order, last field in the lowest bits
  typedef struct packed {
    logic [TIME_BITS-1:0]        now_sec;
    logic                        occupied;
    logic signed [TEMP_BITS-1:0] temp;
  } sample_t;

  typedef struct packed {
    logic [TEMP_BITS-1:0] avg;
    logic                 heat_on;
    logic                 toggled;
    logic                 runtime_valid;
    logic [TIME_BITS-1:0] run_seconds;
  } thermo_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid_i = 1'b0;
  logic                     s_axis_tready_o;
  logic [IN_BITS-1:0]       s_axis_tdata_i = '0;
  logic                     m_axis_tvalid_o;
  logic                     m_axis_tready_i = 1'b0;
  logic [OUT_BITS-1:0]      m_axis_tdata_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_ADDR_BITS-1:0] cfg_addr_i = '0;
  logic [CFG_BITS-1:0]      cfg_data_i = '0;

  averaged_thermostat_hysteresis_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // thermostat shadow: settings and state
  int cfg_target = 1088;
  int cfg_baseline = 960;
  int cfg_lower = 16;
  int cfg_upper = 16;
  int cfg_window = 20;
  int sample_ring [RING_DEPTH];
  int write_slot = 0;
  int running_sum = 0;
  bit primed = 1'b0;
  bit relay_on = 1'b0;
  logic [TIME_BITS-1:0] start_second = '0;

  sample_t        sample_backlog[$];
  thermo_result_t predicted_outputs[$];

  int  src_idle_pct = 0;
  int  sink_stall_pct = 0;
  bit  in_fire = 1'b0;
  int  samples_queued = 0;
  int  samples_taken = 0;
  int  results_seen = 0;
  int  settings_written = 0;
  int  toggles_seen = 0;
  int  runtimes_seen = 0;
  int  mismatch_count = 0;
  bit  occ_state = 1'b1;
  logic [TIME_BITS-1:0] clock_sec = '0;

  function automatic void apply_setting(input logic [CFG_ADDR_BITS-1:0] idx,
                                        input logic [CFG_BITS-1:0] data);
    case (idx)
      REG_TARGET:     cfg_target = int'($signed(data[TEMP_BITS-1:0]));
      REG_BASELINE:   cfg_baseline = int'($signed(data[TEMP_BITS-1:0]));
      REG_LOWER_BAND: cfg_lower = int'(data[BAND_BITS-1:0]);
      REG_UPPER_BAND: cfg_upper = int'(data[BAND_BITS-1:0]);
      REG_WINDOW:     cfg_window = int'(data[WIN_BITS-1:0]);
      default:        return;
    endcase
    primed = 1'b0;
  endfunction

  function automatic thermo_result_t predict_thermostat(input logic [TEMP_BITS-1:0] raw_temp,
                                                        input logic occ,
                                                        input logic [TIME_BITS-1:0] now);
    thermo_result_t r;
    int temp;
    int n;
    int slot;
    int avg;
    int want;
    int k;
    temp = int'($signed(raw_temp));
    n = cfg_window;
    if (n < 1) n = 1;
    if (n > RING_DEPTH) n = RING_DEPTH;
    if (!primed) begin
      // first sample fills the whole window
      for (k = 0; k < RING_DEPTH; k++) sample_ring[k] = temp;
      running_sum = temp * n;
      write_slot = (n > 1) ? 1 : 0;
      primed = 1'b1;
    end else begin
      slot = write_slot;
      if (slot >= n) slot = 0;
      running_sum += temp - sample_ring[slot];
      sample_ring[slot] = temp;
      slot++;
      if (slot >= n) slot = 0;
      write_slot = slot;
    end
    avg = running_sum / n;
    want = -1;
    if (occ && avg <= cfg_target - cfg_lower) want = 1;
    else if (occ && avg >= cfg_target + cfg_upper) want = 0;
    else if (avg <= cfg_baseline - cfg_lower) want = 1;
    else if (!occ && avg >= cfg_baseline + cfg_upper) want = 0;
    r = '0;
    r.avg = TEMP_BITS'(avg);
    if (want >= 0 && ((want == 1) != relay_on)) begin
      r.toggled = 1'b1;
      if (want == 1) begin
        start_second = now;
      end else begin
        r.run_seconds = now - start_second;
        r.runtime_valid = 1'b1;
      end
      relay_on = (want == 1);
    end
    r.heat_on = relay_on;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [TIME_BITS-1:0] exp_v,
                             input logic [TIME_BITS-1:0] got_v);
    if (exp_v !== got_v) begin
      mismatch_count++;
      if (mismatch_count <= 40)
        $display("%0t %s mismatch: expected %h, got %h", $time, name, exp_v, got_v);
    end
  endtask

  // driver: words from the backlog, random gaps; receiver ready at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || in_fire) begin
      if (sample_backlog.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        s_axis_tdata_i <= IN_BITS'(sample_backlog.pop_front());
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
    m_axis_tready_i <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // monitor: predicts on every accepted word and checks every result word
  always @(posedge clk_i) begin : monitor
    thermo_result_t exp_r;
    logic [OUT_BITS-1:0] word;
    in_fire = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && cfg_valid_i && cfg_ready_o) apply_setting(cfg_addr_i, cfg_data_i);
    if (in_fire) begin
      predicted_outputs.push_back(predict_thermostat(s_axis_tdata_i[TEMP_BITS-1:0],
                                                     s_axis_tdata_i[TEMP_BITS],
                                                     s_axis_tdata_i[TEMP_BITS+1 +: TIME_BITS]));
      samples_taken++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      word = m_axis_tdata_o;
      results_seen++;
      if (predicted_outputs.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result word: expected none, got %h", $time, word);
      end else begin
        exp_r = predicted_outputs.pop_front();
        if (exp_r.toggled) toggles_seen++;
        if (exp_r.runtime_valid) runtimes_seen++;
        check_field("average_temp", TIME_BITS'(exp_r.avg), TIME_BITS'(word[TEMP_BITS-1:0]));
        check_field("heat_on", TIME_BITS'(exp_r.heat_on), TIME_BITS'(word[TEMP_BITS]));
        check_field("toggled", TIME_BITS'(exp_r.toggled), TIME_BITS'(word[TEMP_BITS+1]));
        check_field("runtime_valid", TIME_BITS'(exp_r.runtime_valid),
                    TIME_BITS'(word[TEMP_BITS+2]));
        check_field("run_seconds", exp_r.run_seconds, word[TEMP_BITS+3 +: TIME_BITS]);
        check_field("zero fill", '0, TIME_BITS'(word[OUT_BITS-1:OUT_FIELD_BITS]));
      end
    end
  end

  task automatic push_sample(input int t, input logic occ, input logic [TIME_BITS-1:0] now);
    sample_t s;
    if (t > TEMP_MAX) t = TEMP_MAX;
    if (t < TEMP_MIN) t = TEMP_MIN;
    s.temp = TEMP_BITS'(t);
    s.occupied = occ;
    s.now_sec = now;
    sample_backlog.push_back(s);
    samples_queued++;
  endtask

  // sender holds off until the core has returned everything
  task automatic wait_drained();
    do @(negedge clk_i);
    while (!(samples_taken == samples_queued && predicted_outputs.size() == 0));
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_BITS-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    settings_written++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly temperatures around the active setpoint, with some full-range noise
  task automatic random_sample(input bit noise);
    int center;
    int span;
    int t;
    if (noise) begin
      t = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
      push_sample(t, 1'($urandom_range(0, 1)), $urandom);
    end else begin
      if ($urandom_range(0, 11) == 0) occ_state = ~occ_state;
      if ($urandom_range(0, 39) == 0) clock_sec = $urandom;
      else clock_sec = clock_sec + $urandom_range(1, 900);
      center = occ_state ? cfg_target : cfg_baseline;
      span = ((cfg_lower > cfg_upper) ? cfg_lower : cfg_upper) + 24;
      t = center - span + int'($urandom_range(0, 2 * span));
      push_sample(t, occ_state, clock_sec);
    end
  endtask

  initial begin : stimulus
    int ph;
    int i;
    int a;
    int t;
    int win;
    idle_mode_e mode;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default settings, extremes of the sample and of the timestamp
    push_sample(TEMP_MAX, 1'b1, '0);
    push_sample(TEMP_MIN, 1'b0, 32'hFFFF_FFFF);
    push_sample(TEMP_MIN, 1'b1, 32'd5);
    push_sample(0, 1'b0, 32'd6);
    wait_drained();

    // single-sample window: on, off across the seconds wrap, hold, baseline band
    write_reg(REG_WINDOW, CFG_BITS'(1));
    push_sample(1000, 1'b1, 32'hFFFF_FFF0);
    push_sample(1200, 1'b1, 32'h0000_0010);
    push_sample(1088, 1'b1, 32'h0000_0020);
    push_sample(900, 1'b0, 32'h0000_0030);
    push_sample(1000, 1'b0, 32'h0000_0040);
    push_sample(950, 1'b0, 32'h0000_0050);
    wait_drained();

    // window of zero acts as one
    write_reg(REG_WINDOW, '0);
    push_sample(1000, 1'b1, 32'd100);
    push_sample(2000, 1'b1, 32'd200);
    wait_drained();

    // oversized window clamps to the ring depth
    write_reg(REG_WINDOW, '1);
    push_sample(TEMP_MIN, 1'b1, 32'd300);
    push_sample(TEMP_MAX, 1'b1, 32'd400);
    push_sample(TEMP_MAX, 1'b0, 32'd500);
    wait_drained();

    // widest bands, setpoints at opposite extremes
    write_reg(REG_LOWER_BAND, '1);
    write_reg(REG_UPPER_BAND, '1);
    write_reg(REG_TARGET, CFG_BITS'(TEMP_MIN));
    write_reg(REG_BASELINE, CFG_BITS'(TEMP_MAX));
    write_reg(REG_WINDOW, CFG_BITS'(RING_DEPTH));
    push_sample(TEMP_MIN, 1'b1, 32'd1000);
    push_sample(TEMP_MAX, 1'b1, 32'd2000);
    push_sample(TEMP_MAX, 1'b0, 32'd3000);
    wait_drained();

    // writes to unused indexes change nothing and keep the window primed
    for (a = int'(REG_SPARE_FIRST); a <= int'(REG_SPARE_LAST); a++)
      write_reg(CFG_ADDR_BITS'(a), CFG_BITS'($urandom));
    push_sample(TEMP_MIN, 1'b1, 32'd4000);
    push_sample(0, 1'b0, 32'hFFFF_FFFF);
    wait_drained();

    for (ph = 0; ph < PHASES; ph++) begin
      mode = idle_mode_e'(ph % 4);
      case (mode)
        IDLE_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        IDLE_SRC:  begin src_idle_pct = 62; sink_stall_pct = 0;  end
        IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 62; end
        default:   begin src_idle_pct = 28; sink_stall_pct = 28; end
      endcase
      if (ph == 1) begin
        write_reg(REG_TARGET, CFG_BITS'(TEMP_MAX));
        write_reg(REG_BASELINE, CFG_BITS'(TEMP_MIN));
        write_reg(REG_LOWER_BAND, '0);
        write_reg(REG_UPPER_BAND, '0);
        write_reg(REG_WINDOW, CFG_BITS'(1));
      end else if (ph == 6) begin
        write_reg(REG_TARGET, CFG_BITS'(TEMP_MIN));
        write_reg(REG_BASELINE, CFG_BITS'(TEMP_MAX));
        write_reg(REG_LOWER_BAND, CFG_BITS'((1 << BAND_BITS) - 1));
        write_reg(REG_UPPER_BAND, CFG_BITS'((1 << BAND_BITS) - 1));
        write_reg(REG_WINDOW, CFG_BITS'(RING_DEPTH));
      end else begin
        t = int'($urandom_range(0, 4000)) - 2000;
        if ($urandom_range(0, 2) != 0) write_reg(REG_TARGET, CFG_BITS'(t));
        if ($urandom_range(0, 2) != 0)
          write_reg(REG_BASELINE, CFG_BITS'(t - int'($urandom_range(0, 400))));
        // junk in the unused upper data bits must be ignored
        if ($urandom_range(0, 2) != 0)
          write_reg(REG_LOWER_BAND,
                    CFG_BITS'($urandom_range(0, 80) | ($urandom_range(0, 7) << BAND_BITS)));
        if ($urandom_range(0, 2) != 0)
          write_reg(REG_UPPER_BAND,
                    CFG_BITS'($urandom_range(0, 80) | ($urandom_range(0, 7) << BAND_BITS)));
        if ($urandom_range(0, 9) == 0) win = int'($urandom_range(0, 63));
        else win = int'($urandom_range(1, RING_DEPTH));
        write_reg(REG_WINDOW, CFG_BITS'(win | ($urandom_range(0, 511) << WIN_BITS)));
      end
      for (i = 0; i < PHASE_SAMPLES; i++) random_sample($urandom_range(0, 99) < 20);
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    $display("covered %0d samples, %0d register writes, %0d relay toggles, %0d runtimes",
             samples_taken, settings_written, toggles_seen, runtimes_seen);
    $display("checked %0d result words, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("timeout: %0d samples queued, %0d taken, %0d results pending",
             samples_queued, samples_taken, predicted_outputs.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
